// ===== rtl/c8ic_pkg.sv =====
// ----------------------------------------------------------------------------
// c8ic_pkg: shared types and constants of the CHIP-8 instruction core
// Holds the mode codes, reset constants, font table and the command and
// status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package c8ic_pkg;

   localparam int MEM_BYTES_DEFAULT   = 4096;
   localparam int STACK_DEPTH_DEFAULT = 16;

   localparam logic [15:0] START_ADDR  = 16'h0200;
   localparam logic [15:0] FONT_ADDR   = 16'h0050;
   localparam logic [15:0] INDEX_LIMIT = 16'h1000;
   localparam int          FONT_BYTES  = 80;

   localparam logic [2:0] MODE_STEP  = 3'd0;
   localparam logic [2:0] MODE_WRITE = 3'd1;
   localparam logic [2:0] MODE_TICK  = 3'd2;
   localparam logic [2:0] MODE_READ  = 3'd3;
   localparam logic [2:0] MODE_FLAG  = 3'd4;

   localparam logic [1:0] CSR_SHIFT_VY = 2'd0;
   localparam logic [1:0] CSR_JUMP_V0  = 2'd1;
   localparam logic [1:0] CSR_ADV_IDX  = 2'd2;

   // Input request word fields.
   typedef struct packed {
      logic [7:0]  random_byte;
      logic [3:0]  key_event_code;
      logic        key_event_valid;
      logic [15:0] key_state;
      logic [7:0]  data;
      logic [11:0] address;
      logic [2:0]  mode;
   } req_type;

   typedef struct packed {
      logic        stack_fault;
      logic [7:0]  read_data;
      logic        waiting_for_key;
      logic        sound_on;
      logic [3:0]  draw_rows;
      logic [7:0]  draw_y;
      logic [7:0]  draw_x;
      logic        draw_request;
      logic        clear_request;
      logic [15:0] index_value;
      logic [15:0] program_counter;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic       load_req;    // latch request, clear result flags
      logic       do_simple;   // modes other than step and read
      logic       mem_rd;      // issue memory read at the rd_sel address
      logic [1:0] rd_sel;      // 0 pc, 1 pc+1, 2 index+k, 3 address field
      logic       latch_hi;    // opcode high byte from read data
      logic       latch_lo;    // opcode low byte from read data
      logic       exec;        // execute the opcode and advance the pc
      logic       bm_store;    // block move write one byte, k
      logic       bm_load;     // block move load read data into V[k-1]
      logic       bcd_store;   // BCD write one digit, k
      logic       rd_data;     // capture read byte for read mode
      logic       finish;      // block move index update
      logic [3:0] k;
   } cmd_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       is_bm_store;
      logic       is_bm_load;
      logic       is_bcd;
      logic [3:0] x;
   } sts_type;

   function automatic logic [7:0] font_byte(input logic [6:0] idx);
      logic [7:0] f [0:79];
      f = '{8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
            8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
            8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
            8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
            8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
            8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
            8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
            8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80};
      if (idx < 7'(FONT_BYTES)) return f[idx];
      return 8'h00;
   endfunction

endpackage

// ===== rtl/c8ic_datapath.sv =====
// ----------------------------------------------------------------------------
// c8ic_datapath: registers, memory, stack and execution logic
// Carries out the commands of the controller one step at a time.
// ----------------------------------------------------------------------------
module c8ic_datapath
   import c8ic_pkg::*;
#(
   parameter int MEM_BYTES   = MEM_BYTES_DEFAULT,
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    clear_active,
   input  logic [$clog2(MEM_BYTES)-1:0] clear_addr,
   input  req_type req,
   input  cmd_type cmd,
   input  logic    cfg_shift_vy,
   input  logic    cfg_jump_v0,
   input  logic    cfg_adv_idx,
   output sts_type sts,
   output rsp_type rsp
);
   localparam int AW = $clog2(MEM_BYTES);
   localparam int SW = $clog2(STACK_DEPTH);
   localparam int PW = $clog2(STACK_DEPTH + 1);

   logic [7:0]  mem [0:MEM_BYTES-1];
   logic [15:0] stack_mem [0:STACK_DEPTH-1];
   logic [7:0]  rdata_ff;
   logic [7:0]  v_ff [0:15];
   logic [15:0] pc_ff, idx_ff;
   logic [7:0]  dt_ff, st_ff;
   logic [PW-1:0] sp_ff;
   req_type     req_ff;
   logic [15:0] op_ff;
   rsp_type     res_ff;

   logic [3:0] x, y, n;
   logic [7:0] nn, vx, vy;
   logic [11:0] nnn;
   logic [15:0] pc2;
   logic [15:0] rd_full;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [AW-1:0] font_off;
   logic        wr_en;
   logic [7:0]  wr_data;
   logic [7:0]  bcd_digit;
   logic [7:0]  bcd_hund, bcd_rem, bcd_tens, bcd_ones;
   logic [15:0] bcd_prod;

   assign x   = op_ff[11:8];
   assign y   = op_ff[7:4];
   assign n   = op_ff[3:0];
   assign nn  = op_ff[7:0];
   assign nnn = op_ff[11:0];
   assign vx  = v_ff[x];
   assign vy  = v_ff[y];
   assign pc2 = pc_ff + 16'd2;

   assign sts.mode        = req_ff.mode;
   assign sts.is_bm_store = (op_ff[15:12] == 4'hF) && (nn == 8'h55);
   assign sts.is_bm_load  = (op_ff[15:12] == 4'hF) && (nn == 8'h65);
   assign sts.is_bcd      = (op_ff[15:12] == 4'hF) && (nn == 8'h33);
   assign sts.x           = x;

   always_comb begin
      case (cmd.rd_sel)
         2'd0:    rd_full = pc_ff;
         2'd1:    rd_full = pc_ff + 16'd1;
         2'd2:    rd_full = idx_ff + 16'(cmd.k);
         default: rd_full = 16'(req_ff.address);
      endcase
      rd_addr = rd_full[AW-1:0];
   end

   // BCD digit: k=0 hundreds, 1 tens, 2 ones. Hundreds come from two
   // compares, tens from a multiply by 205/2048, which is exact below 100.
   always_comb begin
      if (vx >= 8'd200) begin
         bcd_hund = 8'd2;
         bcd_rem  = vx - 8'd200;
      end else if (vx >= 8'd100) begin
         bcd_hund = 8'd1;
         bcd_rem  = vx - 8'd100;
      end else begin
         bcd_hund = 8'd0;
         bcd_rem  = vx;
      end
      bcd_prod = 16'(bcd_rem) * 16'd205;
      bcd_tens = {3'd0, bcd_prod[15:11]};
      bcd_ones = bcd_rem - bcd_tens * 8'd10;
      case (cmd.k)
         4'd0:    bcd_digit = bcd_hund;
         4'd1:    bcd_digit = bcd_tens;
         default: bcd_digit = bcd_ones;
      endcase
   end

   // Offset into the font; addresses below the font wrap to large values.
   assign font_off = clear_addr - AW'(FONT_ADDR);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clear_addr;
      wr_data = font_byte(font_off[6:0]);
      if (clear_active) begin
         wr_en = 1'b1;
         if (font_off >= AW'(FONT_BYTES)) wr_data = 8'h00;
      end else if (cmd.do_simple && req_ff.mode == MODE_WRITE) begin
         wr_en   = 1'b1;
         wr_addr = AW'(req_ff.address);
         wr_data = req_ff.data;
      end else if (cmd.bm_store) begin
         wr_en   = 1'b1;
         wr_addr = rd_addr;
         wr_data = v_ff[cmd.k];
      end else if (cmd.bcd_store) begin
         wr_en   = 1'b1;
         wr_addr = rd_addr;
         wr_data = bcd_digit;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (cmd.mem_rd) rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      logic [8:0]  sum;
      logic [15:0] inew;
      logic [7:0]  src;
      if (reset) begin
         for (int i = 0; i < 16; i++) v_ff[i] <= 8'h00;
         pc_ff  <= START_ADDR;
         idx_ff <= 16'h0000;
         dt_ff  <= 8'h00;
         st_ff  <= 8'h00;
         sp_ff  <= '0;
         res_ff <= '0;
      end else begin
         if (cmd.load_req) begin
            res_ff <= '0;
         end
         if (cmd.do_simple) begin
            case (req_ff.mode)
               MODE_TICK: begin
                  if (dt_ff != 8'h00) dt_ff <= dt_ff - 8'd1;
                  if (st_ff != 8'h00) st_ff <= st_ff - 8'd1;
               end
               MODE_FLAG: v_ff[15] <= {7'd0, req_ff.data[0]};
               default: ;
            endcase
         end
         if (cmd.rd_data) res_ff.read_data <= rdata_ff;
         if (cmd.bm_load) v_ff[cmd.k - 4'd1] <= rdata_ff;
         if (cmd.finish && cfg_adv_idx)
            idx_ff <= idx_ff + 16'(x) + 16'd1;
         if (cmd.exec) begin
            pc_ff <= pc2;
            case (op_ff[15:12])
               4'h0: begin
                  if (nn == 8'hE0) res_ff.clear_request <= 1'b1;
                  else if (nn == 8'hEE && x == 4'h0) begin
                     if (sp_ff == '0) res_ff.stack_fault <= 1'b1;
                     else begin
                        sp_ff <= sp_ff - PW'(1);
                        pc_ff <= stack_mem[SW'(sp_ff - PW'(1))];
                     end
                  end
               end
               4'h1: pc_ff <= 16'(nnn);
               4'h2: begin
                  if (sp_ff >= PW'(STACK_DEPTH)) res_ff.stack_fault <= 1'b1;
                  else begin
                     sp_ff <= sp_ff + PW'(1);
                     pc_ff <= 16'(nnn);
                  end
               end
               4'h3: if (vx == nn) pc_ff <= pc2 + 16'd2;
               4'h4: if (vx != nn) pc_ff <= pc2 + 16'd2;
               4'h5: if (vx == vy) pc_ff <= pc2 + 16'd2;
               4'h6: v_ff[x] <= nn;
               4'h7: v_ff[x] <= vx + nn;
               4'h8: begin
                  src = cfg_shift_vy ? vy : vx;
                  case (n)
                     4'h0: v_ff[x] <= vy;
                     4'h1: begin v_ff[x] <= vx | vy; v_ff[15] <= 8'h00; end
                     4'h2: begin v_ff[x] <= vx & vy; v_ff[15] <= 8'h00; end
                     4'h3: begin v_ff[x] <= vx ^ vy; v_ff[15] <= 8'h00; end
                     4'h4: begin
                        sum = {1'b0, vx} + {1'b0, vy};
                        v_ff[x] <= sum[7:0];
                        v_ff[15] <= {7'd0, sum[8]};
                     end
                     4'h5: begin
                        v_ff[x] <= vx - vy;
                        v_ff[15] <= {7'd0, vx >= vy};
                     end
                     4'h6: begin
                        v_ff[x] <= src >> 1;
                        v_ff[15] <= {7'd0, src[0]};
                     end
                     4'h7: begin
                        v_ff[x] <= vy - vx;
                        v_ff[15] <= {7'd0, vy >= vx};
                     end
                     4'hE: begin
                        v_ff[x] <= src << 1;
                        v_ff[15] <= {7'd0, src[7]};
                     end
                     default: ;
                  endcase
               end
               4'h9: if (vx != vy) pc_ff <= pc2 + 16'd2;
               4'hA: idx_ff <= 16'(nnn);
               4'hB: pc_ff <= 16'(nnn) + 16'(cfg_jump_v0 ? v_ff[0] : vx);
               4'hC: v_ff[x] <= req_ff.random_byte & nn;
               4'hD: begin
                  res_ff.draw_request <= 1'b1;
                  res_ff.draw_x <= vx;
                  res_ff.draw_y <= vy;
                  res_ff.draw_rows <= n;
               end
               4'hE: begin
                  if ((nn == 8'h9E && req_ff.key_state[vx[3:0]]) ||
                      (nn == 8'hA1 && !req_ff.key_state[vx[3:0]]))
                     pc_ff <= pc2 + 16'd2;
               end
               default: begin
                  case (nn)
                     8'h07: v_ff[x] <= dt_ff;
                     8'h0A: begin
                        if (req_ff.key_event_valid)
                           v_ff[x] <= {4'd0, req_ff.key_event_code};
                        else begin
                           res_ff.waiting_for_key <= 1'b1;
                           pc_ff <= pc_ff;
                        end
                     end
                     8'h15: dt_ff <= vx;
                     8'h18: st_ff <= vx;
                     8'h1E: begin
                        inew = idx_ff + 16'(vx);
                        idx_ff <= inew;
                        if (inew >= INDEX_LIMIT) v_ff[15] <= 8'h01;
                     end
                     8'h29: idx_ff <= FONT_ADDR + 16'({vx[3:0], 2'b00})
                                      + 16'(vx[3:0]);
                     default: ;
                  endcase
               end
            endcase
         end
      end
   end

   // Return stack: written by the call, no reset.
   always_ff @(posedge clock) begin
      if (cmd.exec && op_ff[15:12] == 4'h2 && sp_ff < PW'(STACK_DEPTH))
         stack_mem[SW'(sp_ff)] <= pc2;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req;
      if (cmd.latch_hi) op_ff[15:8] <= rdata_ff;
      if (cmd.latch_lo) op_ff[7:0] <= rdata_ff;
   end

   always_comb begin
      rsp = res_ff;
      rsp.program_counter = pc_ff;
      rsp.index_value     = idx_ff;
      rsp.sound_on        = (st_ff != 8'h00);
   end

endmodule

// ===== rtl/c8ic_controller.sv =====
// ----------------------------------------------------------------------------
// c8ic_controller: sequencing state machine of the instruction core
// Runs the memory clear after reset and steps each request through a simple
// action, a memory read, or fetch, execute and block moves, then responds.
// ----------------------------------------------------------------------------
module c8ic_controller
   import c8ic_pkg::*;
#(
   parameter int MEM_BYTES = MEM_BYTES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    clear_active,
   output logic [$clog2(MEM_BYTES)-1:0] clear_addr
);
   localparam int AW = $clog2(MEM_BYTES);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DISPATCH, S_FETCH_HI, S_FETCH_LO, S_DECODE,
      S_BLOCK, S_BLOCK_WAIT, S_READ_WAIT, S_RESULT
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [3:0]    k_ff, k_in;
   logic          valid_ff, valid_in;

   assign clear_active = (state_ff == S_CLEAR);
   assign clear_addr   = clr_ff;
   assign rsp_valid    = valid_ff;
   // A new request may enter only once the last result is gone or being taken.
   assign req_ready    = (state_ff == S_IDLE) && (!valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      k_in     = k_ff;
      valid_in = valid_ff && !rsp_ready;
      cmd      = '0;
      cmd.k    = k_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(MEM_BYTES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load_req = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (sts.mode == MODE_STEP) begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = 2'd0;
               state_in = S_FETCH_HI;
            end else if (sts.mode == MODE_READ) begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = 2'd3;
               state_in = S_READ_WAIT;
            end else begin
               cmd.do_simple = 1'b1;
               state_in = S_RESULT;
            end
         end
         S_READ_WAIT: begin
            cmd.rd_data = 1'b1;
            state_in = S_RESULT;
         end
         S_FETCH_HI: begin
            cmd.latch_hi = 1'b1;
            cmd.mem_rd = 1'b1;
            cmd.rd_sel = 2'd1;
            state_in = S_FETCH_LO;
         end
         S_FETCH_LO: begin
            cmd.latch_lo = 1'b1;
            k_in = 4'd0;
            state_in = S_DECODE;
         end
         S_DECODE: begin
            if (sts.is_bm_store || sts.is_bm_load || sts.is_bcd) begin
               state_in = S_BLOCK;
            end else begin
               cmd.exec = 1'b1;
               state_in = S_RESULT;
            end
         end
         S_BLOCK: begin
            // One byte per cycle at I+k; loads are written into V from the read register in the following cycle.
            cmd.rd_sel = 2'd2;
            if (sts.is_bcd) begin
               cmd.bcd_store = 1'b1;
               k_in = k_ff + 4'd1;
               if (k_ff == 4'd2) begin
                  cmd.exec = 1'b1;
                  state_in = S_RESULT;
               end
            end else if (sts.is_bm_store) begin
               cmd.bm_store = 1'b1;
               k_in = k_ff + 4'd1;
               if (k_ff == sts.x) begin
                  cmd.exec = 1'b1;
                  cmd.finish = 1'b1;
                  state_in = S_RESULT;
               end
            end else begin
               cmd.mem_rd = 1'b1;
               cmd.bm_load = (k_ff != 4'd0);
               cmd.k = k_ff;
               k_in = k_ff + 4'd1;
               if (k_ff == sts.x) state_in = S_BLOCK_WAIT;
            end
         end
         S_BLOCK_WAIT: begin
            cmd.bm_load = 1'b1;
            cmd.k = k_ff;
            cmd.exec = 1'b1;
            cmd.finish = 1'b1;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         k_ff     <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         k_ff     <= k_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== rtl/chip8_instruction_core.sv =====
// ----------------------------------------------------------------------------
// chip8_instruction_core: CHIP-8 interpreter core
// Memory, registers, stack and timers with a request/response stream port.
// ----------------------------------------------------------------------------
// Usage: each request on req_* carries a mode and its operands; the core
// returns exactly one response on rsp_* with PC, I, display requests, the
// sound flag, the key wait flag, the read byte and the stack fault flag.
// Three quirk registers are to be written through csr_* only while the core
// is idle; the core itself does not enforce it. Simple modes act at dispatch,
// a memory read passes a read wait, and a step fetches, decodes and executes
// its opcode; the single memory port moves one byte per cycle.
// At most one request is in work; a new one is accepted once the core is
// idle, at the earliest in the cycle its predecessor's response is taken.
// After reset the core sweeps main memory once, one byte a cycle, loading
// the font at 0x50 and zeros elsewhere; req_tready stays low throughout the
// sweep. A stalled response holds rsp_tdata steady and the next request
// waits until the response is taken.
// ----------------------------------------------------------------------------
module chip8_instruction_core
   import c8ic_pkg::*;
#(
   parameter int MEM_BYTES   = MEM_BYTES_DEFAULT,
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[2:0], address[14:3], data[22:15], key_state[38:23],
   // key_event_valid[39], key_event_code[43:40], random_byte[51:44]
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // program_counter[15:0], index_value[31:16], clear_request[32],
   // draw_request[33], draw_x[41:34], draw_y[49:42], draw_rows[53:50],
   // sound_on[54], waiting_for_key[55], read_data[63:56], stack_fault[64]
   output logic [71:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   localparam int AW = $clog2(MEM_BYTES);

   req_type       req;
   rsp_type       rsp;
   cmd_type       cmd;
   sts_type       sts;
   logic          clear_active;
   logic [AW-1:0] clear_addr;
   logic          shift_vy_ff, jump_v0_ff, adv_idx_ff;

   // The request fields sit packed from bit 0: mode, address, data,
   // key_state, key_event_valid, key_event_code, random_byte (bits 51:44).
   assign req = req_type'(req_tdata[51:0]);
   assign rsp_tdata = {7'd0, rsp};

   // Quirk registers; writes are taken at any time.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_vy_ff <= 1'b0;
         jump_v0_ff  <= 1'b1;
         adv_idx_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SHIFT_VY: shift_vy_ff <= csr_data[0];
            CSR_JUMP_V0:  jump_v0_ff  <= csr_data[0];
            CSR_ADV_IDX:  adv_idx_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   c8ic_controller #(.MEM_BYTES(MEM_BYTES)) u_ctrl (
      .clock, .reset,
      .req_valid(req_tvalid), .req_ready(req_tready),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .sts, .cmd, .clear_active, .clear_addr
   );

   c8ic_datapath #(.MEM_BYTES(MEM_BYTES), .STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock, .reset, .clear_active, .clear_addr, .req, .cmd,
      .cfg_shift_vy(shift_vy_ff), .cfg_jump_v0(jump_v0_ff),
      .cfg_adv_idx(adv_idx_ff), .sts, .rsp
   );

endmodule

// ===== rtl/c8ic_checker.sv =====
// ----------------------------------------------------------------------------
// c8ic_checker: port level checks of the instruction core
// Watches the stream ports for ordering of requests and responses.
// ----------------------------------------------------------------------------
module c8ic_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);
   // A response never shows up in the cycle right after a request is taken.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))
      else $error("response too early");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // Only one request in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request accepted");

   // The unused top bits of the response are zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[71:65] == 7'd0)
      else $error("response padding nonzero");
endmodule

bind chip8_instruction_core c8ic_checker u_chk (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tdata
);

// ===== bench/chip8_instruction_core_test.sv =====
// ----------------------------------------------------------------------------
// chip8_instruction_core_test: self-checking bench of the CHIP-8 core
// Drives requests over the stream port, predicts every response with a
// behavioral model of the core kept inside the bench, and compares each
// response field by field. A short table of directed requests comes first,
// then random instruction sequences under several quirk settings.
// ----------------------------------------------------------------------------
module chip8_instruction_core_test
   import c8ic_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // Opcode groups, taken from the top nibble of an instruction.
   localparam logic [3:0] OP_SYS = 4'h0, OP_JP = 4'h1, OP_CALL = 4'h2, OP_SE = 4'h3;
   localparam logic [3:0] OP_SNE = 4'h4, OP_SER = 4'h5, OP_LD = 4'h6, OP_ADD = 4'h7;
   localparam logic [3:0] OP_ALU = 4'h8, OP_SNER = 4'h9, OP_LDI = 4'hA, OP_JPV = 4'hB;
   localparam logic [3:0] OP_RND = 4'hC, OP_DRW = 4'hD, OP_KEY = 4'hE, OP_MISC = 4'hF;
   // Register-to-register operations, selected by the low nibble.
   localparam logic [3:0] ALU_MOV = 4'h0, ALU_OR = 4'h1, ALU_AND = 4'h2, ALU_XOR = 4'h3;
   localparam logic [3:0] ALU_ADD = 4'h4, ALU_SUB = 4'h5, ALU_SHR = 4'h6;
   localparam logic [3:0] ALU_SUBN = 4'h7, ALU_SHL = 4'hE;
   // Low-byte selectors of the system, key and miscellaneous groups.
   localparam logic [7:0] SYS_CLS = 8'hE0, SYS_RET = 8'hEE;
   localparam logic [7:0] KEY_DOWN = 8'h9E, KEY_UP = 8'hA1;
   localparam logic [7:0] F_GETDT = 8'h07, F_WAITK = 8'h0A, F_SETDT = 8'h15;
   localparam logic [7:0] F_SETST = 8'h18, F_ADDI = 8'h1E, F_FONT = 8'h29;
   localparam logic [7:0] F_BCD = 8'h33, F_STORE = 8'h55, F_LOAD = 8'h65;
   localparam logic [2:0] MODE_IDLE5 = 3'd5, MODE_IDLE7 = 3'd7;

   localparam int DRAIN_CYCLES = 30;   // longest request is a 16 byte block move
   localparam int HOLD_CYCLES  = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   always #6 clock = ~clock;

   chip8_instruction_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Bench copy of the core state and quirk settings.
   logic [7:0]  ram [0:4095];
   logic [7:0]  vreg [0:15];
   logic [15:0] ret_stack [0:15];
   logic [15:0] pc_r, idx_r;
   logic [7:0]  delay_r, sound_r;
   int          depth;
   logic        q_shift_vy, q_jump_v0, q_adv_idx;

   rsp_type pending_rsp [$];
   int      errors = 0;
   int      sent = 0;
   bit      calm = 1'b0;       // no idling on either side while set
   int      hold_requests = 0;
   int      hold_served = 0;
   int      hold_left = 0;

   function automatic logic [7:0] font_ref(int i);
      logic [7:0] g [0:79];
      g = '{8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
            8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
            8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
            8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
            8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
            8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
            8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
            8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80};
      return g[i];
   endfunction

   // The bench state after reset: font at its base address, pc at the start.
   task automatic model_reset();
      for (int a = 0; a < 4096; a++) begin
         ram[a] = (a >= FONT_ADDR && a < FONT_ADDR + FONT_BYTES) ?
                  font_ref(a - FONT_ADDR) : 8'h00;
      end
      for (int k = 0; k < 16; k++) begin
         vreg[k] = '0;
         ret_stack[k] = '0;
      end
      pc_r = START_ADDR;
      idx_r = '0;
      delay_r = '0;
      sound_r = '0;
      depth = 0;
      q_shift_vy = 1'b0;
      q_jump_v0 = 1'b1;
      q_adv_idx = 1'b0;
   endtask

   // Applies one request to the bench state and returns the response it
   // should produce.
   function automatic rsp_type run_request(req_type q);
      rsp_type     r;
      logic [15:0] op;
      logic [3:0]  x, y, n;
      logic [7:0]  nn, vx;
      logic        f;
      logic [8:0]  sum;
      r = '0;
      case (q.mode)
         MODE_STEP: begin
            op = {ram[pc_r[11:0]], ram[12'(pc_r + 16'd1)]};
            x = op[11:8];
            y = op[7:4];
            n = op[3:0];
            nn = op[7:0];
            pc_r = pc_r + 16'd2;
            case (op[15:12])
               OP_SYS: begin
                  if (nn == SYS_CLS) begin
                     r.clear_request = 1'b1;
                  end else if (nn == SYS_RET && x == 4'h0) begin
                     // A return on an empty stack is flagged and skipped.
                     if (depth == 0) begin
                        r.stack_fault = 1'b1;
                     end else begin
                        depth--;
                        pc_r = ret_stack[depth];
                     end
                  end
               end
               OP_JP: pc_r = {4'h0, op[11:0]};
               OP_CALL: begin
                  if (depth >= 16) begin
                     r.stack_fault = 1'b1;
                  end else begin
                     ret_stack[depth] = pc_r;
                     depth++;
                     pc_r = {4'h0, op[11:0]};
                  end
               end
               OP_SE:   if (vreg[x] == nn) pc_r = pc_r + 16'd2;
               OP_SNE:  if (vreg[x] != nn) pc_r = pc_r + 16'd2;
               OP_SER:  if (vreg[x] == vreg[y]) pc_r = pc_r + 16'd2;
               OP_LD:   vreg[x] = nn;
               OP_ADD:  vreg[x] = vreg[x] + nn;
               OP_ALU: begin
                  case (n)
                     ALU_MOV: vreg[x] = vreg[y];
                     ALU_OR: begin
                        vreg[x] = vreg[x] | vreg[y];
                        vreg[15] = '0;
                     end
                     ALU_AND: begin
                        vreg[x] = vreg[x] & vreg[y];
                        vreg[15] = '0;
                     end
                     ALU_XOR: begin
                        vreg[x] = vreg[x] ^ vreg[y];
                        vreg[15] = '0;
                     end
                     ALU_ADD: begin
                        sum = {1'b0, vreg[x]} + {1'b0, vreg[y]};
                        vreg[x] = sum[7:0];
                        vreg[15] = {7'd0, sum[8]};
                     end
                     ALU_SUB: begin
                        f = vreg[x] >= vreg[y];
                        vreg[x] = vreg[x] - vreg[y];
                        vreg[15] = {7'd0, f};
                     end
                     ALU_SHR: begin
                        if (q_shift_vy) vreg[x] = vreg[y];
                        f = vreg[x][0];
                        vreg[x] = vreg[x] >> 1;
                        vreg[15] = {7'd0, f};
                     end
                     ALU_SUBN: begin
                        f = vreg[y] >= vreg[x];
                        vreg[x] = vreg[y] - vreg[x];
                        vreg[15] = {7'd0, f};
                     end
                     ALU_SHL: begin
                        if (q_shift_vy) vreg[x] = vreg[y];
                        f = vreg[x][7];
                        vreg[x] = vreg[x] << 1;
                        vreg[15] = {7'd0, f};
                     end
                     default: ;
                  endcase
               end
               OP_SNER: if (vreg[x] != vreg[y]) pc_r = pc_r + 16'd2;
               OP_LDI:  idx_r = {4'h0, op[11:0]};
               OP_JPV:  pc_r = {4'h0, op[11:0]} + {8'h00, q_jump_v0 ? vreg[0] : vreg[x]};
               OP_RND:  vreg[x] = q.random_byte & nn;
               OP_DRW: begin
                  r.draw_request = 1'b1;
                  r.draw_x = vreg[x];
                  r.draw_y = vreg[y];
                  r.draw_rows = n;
               end
               OP_KEY: begin
                  f = q.key_state[vreg[x][3:0]];
                  if ((nn == KEY_DOWN && f) || (nn == KEY_UP && !f)) pc_r = pc_r + 16'd2;
               end
               default: begin
                  case (nn)
                     F_GETDT: vreg[x] = delay_r;
                     F_WAITK: begin
                        // Without a key event the instruction repeats.
                        if (q.key_event_valid) begin
                           vreg[x] = {4'h0, q.key_event_code};
                        end else begin
                           r.waiting_for_key = 1'b1;
                           pc_r = pc_r - 16'd2;
                        end
                     end
                     F_SETDT: delay_r = vreg[x];
                     F_SETST: sound_r = vreg[x];
                     F_ADDI: begin
                        idx_r = idx_r + {8'h00, vreg[x]};
                        if (idx_r >= INDEX_LIMIT) vreg[15] = 8'd1;
                     end
                     F_FONT: idx_r = FONT_ADDR + 16'(5 * vreg[x][3:0]);
                     F_BCD: begin
                        vx = vreg[x];
                        ram[idx_r[11:0]] = vx / 8'd100;
                        ram[12'(idx_r + 16'd1)] = (vx / 8'd10) % 8'd10;
                        ram[12'(idx_r + 16'd2)] = vx % 8'd10;
                     end
                     F_STORE, F_LOAD: begin
                        for (int k = 0; k <= x; k++) begin
                           if (nn == F_STORE) ram[12'(idx_r + k)] = vreg[k];
                           else vreg[k] = ram[12'(idx_r + k)];
                        end
                        if (q_adv_idx) idx_r = idx_r + {12'd0, x} + 16'd1;
                     end
                     default: ;
                  endcase
               end
            endcase
         end
         MODE_WRITE: ram[q.address] = q.data;
         MODE_TICK: begin
            if (delay_r != 0) delay_r--;
            if (sound_r != 0) sound_r--;
         end
         MODE_READ: r.read_data = ram[q.address];
         MODE_FLAG: vreg[15] = {7'd0, q.data[0]};
         default: ;
      endcase
      r.program_counter = pc_r;
      r.index_value = idx_r;
      r.sound_on = sound_r != 0;
      return r;
   endfunction

   // Offers one request; once it is taken, the expected response is queued.
   // A typed-in expectation replaces the predicted one, but the bench state
   // still advances through the predictor.
   task automatic send_req(req_type q, bit typed, rsp_type given);
      rsp_type p;
      if (!calm && $urandom_range(0, 99) < 10) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'd0, q};
      do @(posedge clock); while (!req_tready);
      p = run_request(q);
      pending_rsp.push_back(typed ? given : p);
      sent++;
   endtask

   function automatic req_type mkreq(logic [2:0] mode, logic [11:0] address,
                                     logic [7:0] data);
      req_type q;
      q = '0;
      q.mode = mode;
      q.address = address;
      q.data = data;
      return q;
   endfunction

   function automatic rsp_type mkrsp(logic [15:0] pc, logic [15:0] ix);
      rsp_type r;
      r = '0;
      r.program_counter = pc;
      r.index_value = ix;
      return r;
   endfunction

   function automatic req_type rand_req();
      req_type q;
      q.mode = 3'($urandom_range(0, 7));
      q.address = 12'($urandom);
      q.data = 8'($urandom);
      q.key_state = 16'($urandom);
      q.key_event_valid = 1'($urandom);
      q.key_event_code = 4'($urandom);
      q.random_byte = 8'($urandom);
      return q;
   endfunction

   function automatic logic [15:0] rand_opcode();
      logic [15:0] op;
      logic [7:0]  misc [0:8];
      misc = '{F_GETDT, F_WAITK, F_SETDT, F_SETST, F_ADDI, F_FONT, F_BCD, F_STORE, F_LOAD};
      op = 16'($urandom);
      case (op[15:12])
         OP_SYS: begin
            case ($urandom_range(0, 3))
               0: op[11:0] = {4'h0, SYS_CLS};
               1, 2: op[11:0] = {4'h0, SYS_RET};
               default: ;
            endcase
         end
         OP_ALU: if ($urandom_range(0, 3) != 0) op[3:0] = 4'($urandom_range(0, 7));
         OP_KEY: begin
            case ($urandom_range(0, 4))
               0, 1: op[7:0] = KEY_DOWN;
               2, 3: op[7:0] = KEY_UP;
               default: ;
            endcase
         end
         OP_MISC: if ($urandom_range(0, 9) != 0) op[7:0] = misc[$urandom_range(0, 8)];
         default: ;
      endcase
      return op;
   endfunction

   // Places an instruction at the current pc and executes it.
   task automatic run_instruction(logic [15:0] op);
      req_type q;
      send_req(mkreq(MODE_WRITE, pc_r[11:0], op[15:8]), 1'b0, '0);
      send_req(mkreq(MODE_WRITE, 12'(pc_r + 16'd1), op[7:0]), 1'b0, '0);
      q = rand_req();
      q.mode = MODE_STEP;
      send_req(q, 1'b0, '0);
   endtask

   // Lets every outstanding response arrive, plus the longest request time.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_quirks(logic shift_vy, logic jump_v0, logic adv_idx);
      logic [1:0] idx [0:2];
      logic       val [0:2];
      idx = '{CSR_SHIFT_VY, CSR_JUMP_V0, CSR_ADV_IDX};
      val = '{shift_vy, jump_v0, adv_idx};
      for (int k = 0; k < 3; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data <= {7'd0, val[k]};
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      q_shift_vy = shift_vy;
      q_jump_v0 = jump_v0;
      q_adv_idx = adv_idx;
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
         errors++;
      end
   endtask

   // Response checker: each accepted response is compared with the oldest
   // expectation.
   always @(posedge clock) begin
      rsp_type e, a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         a = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
         if (pending_rsp.size() == 0) begin
            $display("%0t: response with none expected, actual %0h", $realtime, a);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            check_field("program_counter", e.program_counter, a.program_counter);
            check_field("index_value", e.index_value, a.index_value);
            check_field("clear_request", e.clear_request, a.clear_request);
            check_field("draw_request", e.draw_request, a.draw_request);
            check_field("draw_x", e.draw_x, a.draw_x);
            check_field("draw_y", e.draw_y, a.draw_y);
            check_field("draw_rows", e.draw_rows, a.draw_rows);
            check_field("sound_on", e.sound_on, a.sound_on);
            check_field("waiting_for_key", e.waiting_for_key, a.waiting_for_key);
            check_field("read_data", e.read_data, a.read_data);
            check_field("stack_fault", e.stack_fault, a.stack_fault);
         end
      end
   end

   // Response side: random stalls, and on request one long hold-off so the
   // core fills up and stops taking requests.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_requests != hold_served) begin
         rsp_tready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_served <= hold_served + 1;
      end else begin
         rsp_tready <= calm || ($urandom_range(0, 99) >= 10);
      end
   end

   initial begin
      req_type    dir_req [$];
      bit         dir_typed [$];
      rsp_type    dir_rsp [$];
      req_type    q;
      rsp_type    r;
      logic [2:0] mix;
      model_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed table. Rows with a typed-in response follow from the reset
      // state at a glance; the others are left to the predictor.
      r = mkrsp(START_ADDR, 16'h0000);
      r.read_data = 8'hF0;                        // first font byte
      dir_req.push_back(mkreq(MODE_READ, FONT_ADDR[11:0], 8'h00));
      dir_typed.push_back(1'b1); dir_rsp.push_back(r);
      dir_req.push_back(mkreq(MODE_READ, 12'hFFF, 8'hFF));
      dir_typed.push_back(1'b1); dir_rsp.push_back(mkrsp(START_ADDR, 16'h0000));
      dir_req.push_back(mkreq(MODE_TICK, 12'h000, 8'h00));
      dir_typed.push_back(1'b1); dir_rsp.push_back(mkrsp(START_ADDR, 16'h0000));
      dir_req.push_back(mkreq(MODE_FLAG, 12'h000, 8'hFF));
      dir_typed.push_back(1'b1); dir_rsp.push_back(mkrsp(START_ADDR, 16'h0000));
      // Return on an empty stack: flagged, pc just moves past it.
      dir_req.push_back(mkreq(MODE_WRITE, 12'h200, 8'h00));
      dir_typed.push_back(1'b0); dir_rsp.push_back('0);
      dir_req.push_back(mkreq(MODE_WRITE, 12'h201, SYS_RET));
      dir_typed.push_back(1'b0); dir_rsp.push_back('0);
      r = mkrsp(16'h0202, 16'h0000);
      r.stack_fault = 1'b1;
      dir_req.push_back(mkreq(MODE_STEP, 12'h000, 8'h00));
      dir_typed.push_back(1'b1); dir_rsp.push_back(r);
      // Display clear.
      dir_req.push_back(mkreq(MODE_WRITE, 12'h202, 8'h00));
      dir_typed.push_back(1'b0); dir_rsp.push_back('0);
      dir_req.push_back(mkreq(MODE_WRITE, 12'h203, SYS_CLS));
      dir_typed.push_back(1'b0); dir_rsp.push_back('0);
      r = mkrsp(16'h0204, 16'h0000);
      r.clear_request = 1'b1;
      dir_req.push_back(mkreq(MODE_STEP, 12'h000, 8'h00));
      dir_typed.push_back(1'b1); dir_rsp.push_back(r);
      // Draw with the tallest sprite.
      dir_req.push_back(mkreq(MODE_WRITE, 12'h204, 8'hD1));
      dir_typed.push_back(1'b0); dir_rsp.push_back('0);
      dir_req.push_back(mkreq(MODE_WRITE, 12'h205, 8'h2F));
      dir_typed.push_back(1'b0); dir_rsp.push_back('0);
      r = mkrsp(16'h0206, 16'h0000);
      r.draw_request = 1'b1;
      r.draw_rows = 4'hF;
      dir_req.push_back(mkreq(MODE_STEP, 12'h000, 8'h00));
      dir_typed.push_back(1'b1); dir_rsp.push_back(r);
      // Key wait: first without an event, then with one.
      dir_req.push_back(mkreq(MODE_WRITE, 12'h206, 8'hF3));
      dir_typed.push_back(1'b0); dir_rsp.push_back('0);
      dir_req.push_back(mkreq(MODE_WRITE, 12'h207, F_WAITK));
      dir_typed.push_back(1'b0); dir_rsp.push_back('0);
      r = mkrsp(16'h0206, 16'h0000);
      r.waiting_for_key = 1'b1;
      dir_req.push_back(mkreq(MODE_STEP, 12'h000, 8'h00));
      dir_typed.push_back(1'b1); dir_rsp.push_back(r);
      q = mkreq(MODE_STEP, 12'h000, 8'h00);
      q.key_event_valid = 1'b1;
      q.key_event_code = 4'hF;
      dir_req.push_back(q);
      dir_typed.push_back(1'b0); dir_rsp.push_back('0);
      // Largest index load.
      dir_req.push_back(mkreq(MODE_WRITE, 12'h208, 8'hAF));
      dir_typed.push_back(1'b0); dir_rsp.push_back('0);
      dir_req.push_back(mkreq(MODE_WRITE, 12'h209, 8'hFF));
      dir_typed.push_back(1'b0); dir_rsp.push_back('0);
      dir_req.push_back(mkreq(MODE_STEP, 12'h000, 8'h00));
      dir_typed.push_back(1'b1); dir_rsp.push_back(mkrsp(16'h020A, 16'h0FFF));
      // Unused modes with every field at its top, then at zero.
      q = '1;
      q.mode = MODE_IDLE7;
      dir_req.push_back(q);
      dir_typed.push_back(1'b0); dir_rsp.push_back('0);
      dir_req.push_back(mkreq(MODE_IDLE5, 12'h000, 8'h00));
      dir_typed.push_back(1'b0); dir_rsp.push_back('0);

      for (int k = 0; k < dir_req.size(); k++) send_req(dir_req[k], dir_typed[k], dir_rsp[k]);

      // Random phases, each under its own quirk setting. One phase runs
      // with no idling, one starts with the long response hold-off, and
      // one runs a burst of calls and returns past both stack limits.
      for (int ph = 0; ph < 5; ph++) begin
         drain();
         case (ph)
            0: set_quirks(1'b0, 1'b1, 1'b0);
            1: set_quirks(1'b1, 1'b0, 1'b1);
            2: set_quirks(1'b0, 1'b0, 1'b0);
            3: set_quirks(1'b1, 1'b1, 1'b1);
            default: set_quirks(1'($urandom), 1'($urandom), 1'($urandom));
         endcase
         calm = (ph == 3);
         if (ph == 1) hold_requests++;
         if (ph == 2) begin
            repeat (18) run_instruction({OP_CALL, 12'($urandom)});
            repeat (19) run_instruction({OP_SYS, 4'h0, SYS_RET});
         end
         while (sent < 22 + (ph + 1) * 150) begin
            mix = 3'($urandom_range(0, 9));
            if (mix < 7) begin
               run_instruction(rand_opcode());
            end else begin
               send_req(rand_req(), 1'b0, '0);
            end
         end
      end

      drain();
      calm = 1'b0;
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Run limit, far beyond the slowest correct run including the memory
   // sweep after reset and the long hold-off.
   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

endmodule

// ===== chip8_instruction_core.f =====
rtl/c8ic_pkg.sv
rtl/c8ic_datapath.sv
rtl/c8ic_controller.sv
rtl/chip8_instruction_core.sv
rtl/c8ic_checker.sv
bench/chip8_instruction_core_test.sv
